// ===== rtl/b64e_pkg.sv =====
// Package with shared types, constants and the character table of the Base64 encoder.
package b64e_pkg;

	localparam logic [7:0] PadChar = 8'h3D;
	localparam int unsigned JobDepth = 2;

	typedef enum logic [1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2
	} phase_t;

	typedef struct packed {
		logic [3:0][5:0] sextet;
		logic [3:0]      pad;
		logic [1:0]      last_idx;
		logic            fin;
	} job_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		logic [7:0] c;
		case (s) inside
			[6'd0:6'd25]:  c = 8'h41 + {2'b00, s};
			[6'd26:6'd51]: c = 8'h61 + {2'b00, s} - 8'd26;
			[6'd52:6'd61]: c = 8'h30 + {2'b00, s} - 8'd52;
			6'd62:         c = 8'h2B;
			default:       c = 8'h2F;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// Front end: tracks the group phase and carry bits and turns each byte into a character job.
module b64e_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         data_byte,
	input  logic               final_byte,
	output b64e_pkg::job_t     job
);

	b64e_pkg::phase_t phase_q;
	logic [3:0]       carry_q;
	b64e_pkg::phase_t phase_d;
	logic [3:0]       carry_d;

	always_comb begin
		job = '0;
		job.fin = final_byte;
		case (phase_q)
			b64e_pkg::PH_1: begin
				job.sextet[0] = {carry_q[1:0], data_byte[7:4]};
				job.sextet[1] = {data_byte[3:0], 2'b00};
				job.pad = 4'b0100;
				job.last_idx = final_byte ? 2'd2 : 2'd0;
				carry_d = data_byte[3:0];
				phase_d = b64e_pkg::PH_2;
			end
			b64e_pkg::PH_2: begin
				job.sextet[0] = {carry_q, data_byte[7:6]};
				job.sextet[1] = data_byte[5:0];
				job.last_idx = 2'd1;
				carry_d = 4'd0;
				phase_d = b64e_pkg::PH_0;
			end
			default: begin
				job.sextet[0] = data_byte[7:2];
				job.sextet[1] = {data_byte[1:0], 4'b0000};
				job.pad = 4'b1100;
				job.last_idx = final_byte ? 2'd3 : 2'd0;
				carry_d = {2'b00, data_byte[1:0]};
				phase_d = b64e_pkg::PH_1;
			end
		endcase
		if (final_byte) begin
			carry_d = 4'd0;
			phase_d = b64e_pkg::PH_0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64e_pkg::PH_0;
			carry_q <= 4'd0;
		end else if (take) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

endmodule

// ===== rtl/b64e_jobq.sv =====
// Short queue of character jobs between the front end and the back end.
module b64e_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  b64e_pkg::job_t wr_job,
	output logic           q_full,
	input  logic           rd_en,
	output b64e_pkg::job_t rd_job,
	output logic           q_empty
);

	localparam int unsigned PtrW = $clog2(b64e_pkg::JobDepth);

	b64e_pkg::job_t       mem_q [b64e_pkg::JobDepth];
	logic [PtrW-1:0]      wr_ptr_q;
	logic [PtrW-1:0]      rd_ptr_q;
	logic [PtrW:0]        count_q;

	assign q_full  = (count_q == (PtrW+1)'(b64e_pkg::JobDepth));
	assign q_empty = (count_q == '0);
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: walks each job one character a cycle to the output register when free.
module b64e_back (
	input  logic           clk,
	input  logic           arst_n,
	input  b64e_pkg::job_t job,
	input  logic           job_valid,
	output logic           job_done,
	output logic [7:0]     out_char,
	output logic           out_last,
	output logic           empty,
	input  logic           pop
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       advance;
	logic       at_end;

	assign advance  = (!valid_q || pop) && job_valid;
	assign at_end   = (idx_q == job.last_idx);
	assign job_done = advance && at_end;
	assign empty    = !valid_q;
	assign out_char = char_q;
	assign out_last = last_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			char_q <= job.pad[idx_q] ? b64e_pkg::PadChar
				: b64e_pkg::sextet_char(job.sextet[idx_q]);
			last_q <= at_end && job.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// Top level of the Base64 stream encoder.
//
// Channel  | Handshake     | Payload
// input    | push / full   | data_byte, final_byte
// result   | empty / pop   | out_char, out_last
//
// The back end emits one character per cycle while results are popped; a byte yields
// one or two characters, about 4/3 on average, and four for a final byte in the first phase.
// A byte is taken in any cycle in which the two-entry job queue has room.
// A result waiting in the output register holds the back end; the front end stalls once the queue is full.
// Reset clears the phase, carry bits, queue pointers and the output valid flag at once.
module base64_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       out_last
);

	b64e_pkg::job_t wr_job;
	b64e_pkg::job_t rd_job;
	logic           take;
	logic           q_empty;
	logic           job_done;

	assign take = push && !full;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.job        (wr_job)
	);

	b64e_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_job  (wr_job),
		.q_full  (full),
		.rd_en   (job_done),
		.rd_job  (rd_job),
		.q_empty (q_empty)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (rd_job),
		.job_valid (!q_empty),
		.job_done  (job_done),
		.out_char  (out_char),
		.out_last  (out_last),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== rtl/b64e_checker.sv =====
// Port checker for the Base64 stream encoder and its bind statement.
module b64e_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_char,
	input logic       out_last
);

	property p_hold;
		@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_char) && $stable(out_last);
	endproperty
	a_hold: assert property (p_hold) else $error("result changed while stalled");

	property p_charset;
		@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_char >= 8'h41 && out_char <= 8'h5A)
			|| (out_char >= 8'h61 && out_char <= 8'h7A)
			|| (out_char >= 8'h30 && out_char <= 8'h39)
			|| out_char == 8'h2B || out_char == 8'h2F || out_char == b64e_pkg::PadChar;
	endproperty
	a_charset: assert property (p_charset) else $error("character outside the alphabet");

	property p_pad_pair;
		@(posedge clk) disable iff (!arst_n)
		pop && !empty && out_char == b64e_pkg::PadChar && !out_last
			|=> !empty && out_char == b64e_pkg::PadChar;
	endproperty
	a_pad_pair: assert property (p_pad_pair) else $error("first pad not followed by a pad");

	property p_pad_then_last;
		@(posedge clk) disable iff (!arst_n)
		pop && !empty && out_char == b64e_pkg::PadChar && !out_last
			|=> out_last;
	endproperty
	a_pad_then_last: assert property (p_pad_then_last) else $error("pad run too long");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.out_char (out_char),
	.out_last (out_last)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Base64 stream encoder with a built-in character predictor.
module tb;

	localparam int unsigned CycleLimit = 500000;
	localparam string Alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} b64_char_t;

	typedef logic [7:0] byte_q_t[$];

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] data_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_char;
	logic       out_last;

	b64_char_t          pending_chars[$];
	b64e_pkg::phase_t   enc_phase = b64e_pkg::PH_0;
	logic [3:0]         enc_carry = 4'h0;
	int unsigned        mismatches = 0;
	int unsigned        cycles = 0;
	bit                 tx_idle = 1'b1;
	bit                 rx_idle = 1'b1;
	int unsigned        rx_hold = 0;

	base64_stream_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.final_byte(final_byte),
		.empty     (empty),
		.pop       (pop),
		.out_char  (out_char),
		.out_last  (out_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] b64_char(input logic [5:0] s);
		return 8'(Alphabet[int'(s)]);
	endfunction

	function automatic void queue_char(input logic [7:0] ch, input logic last);
		b64_char_t c;
		c.ch = ch;
		c.last = last;
		pending_chars = {pending_chars, c};
	endfunction

	// Works out the characters that one accepted byte produces.
	function automatic void encode_byte(input logic [7:0] b, input logic fin);
		case (enc_phase)
			b64e_pkg::PH_1: begin
				queue_char(b64_char({enc_carry[1:0], b[7:4]}), 1'b0);
				enc_carry = b[3:0];
				enc_phase = b64e_pkg::PH_2;
				if (fin) begin
					queue_char(b64_char({enc_carry, 2'b00}), 1'b0);
					queue_char(b64e_pkg::PadChar, 1'b1);
				end
			end
			b64e_pkg::PH_2: begin
				queue_char(b64_char({enc_carry, b[7:6]}), 1'b0);
				queue_char(b64_char(b[5:0]), fin);
				enc_carry = 4'h0;
				enc_phase = b64e_pkg::PH_0;
			end
			default: begin
				queue_char(b64_char(b[7:2]), 1'b0);
				enc_carry = {2'b00, b[1:0]};
				enc_phase = b64e_pkg::PH_1;
				if (fin) begin
					queue_char(b64_char({enc_carry[1:0], 4'h0}), 1'b0);
					queue_char(b64e_pkg::PadChar, 1'b0);
					queue_char(b64e_pkg::PadChar, 1'b1);
				end
			end
		endcase
		if (fin) begin
			enc_phase = b64e_pkg::PH_0;
			enc_carry = 4'h0;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		push <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (full);
		encode_byte(b, fin);
	endtask

	task automatic send_message(input byte_q_t msg);
		foreach (msg[i]) begin
			if (tx_idle && $urandom_range(0, 3) == 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			send_byte(msg[i], i == msg.size() - 1);
		end
	endtask

	function automatic byte_q_t random_message(input int unsigned len);
		byte_q_t msg;
		repeat (len) msg = {msg, 8'($urandom_range(0, 255))};
		return msg;
	endfunction

	task automatic wait_drained();
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	task automatic test_known_vectors();
		send_message({8'h4D});
		send_message({8'h4D, 8'h61});
		send_message({8'h4D, 8'h61, 8'h6E});
		send_message({8'h00});
		send_message({8'hFF});
		send_message({8'hFF, 8'h00});
		send_message({8'h00, 8'hFF, 8'h80});
		send_message({8'hFB, 8'hFF, 8'hBF});
		send_message({8'h4D, 8'h61, 8'h6E, 8'h79});
	endtask

	task automatic test_random_messages();
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < 300) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			send_message(random_message(len));
			sent += len;
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// The receiver holds off while bytes keep coming, so the input side must stall.
	task automatic test_full_stall();
		tx_idle = 1'b0;
		rx_hold = 120;
		send_message(random_message(17));
		send_message(random_message(13));
		tx_idle = 1'b1;
	endtask

	task automatic test_drain_pause();
		send_message(random_message(7));
		push <= 1'b0;
		wait_drained();
		send_message(random_message(6));
	endtask

	task automatic test_steady_stream();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_message(random_message(20));
		send_message(random_message(1));
		send_message(random_message(11));
		send_message(random_message(12));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_known_vectors();
		test_random_messages();
		test_full_stall();
		test_drain_pause();
		test_steady_stream();
		push <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		wait (arst_n);
		forever begin
			if (rx_hold > 0) begin
				pop <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		b64_char_t want;
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n && pop && !empty) begin
			if (pending_chars.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer, expected none, actual %h last %b",
					$time, out_char, out_last);
			end else begin
				want = pending_chars.pop_front();
				if (out_char !== want.ch) begin
					mismatches++;
					$display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
				end
				if (out_last !== want.last) begin
					mismatches++;
					$display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
				end
			end
		end
	end

endmodule

// ===== sim.f =====
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_jobq.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
rtl/b64e_checker.sv
bench/tb.sv
